// File: src/pxb_pkg.sv
package pxb_pkg;

	// Destination pixel layouts held in the format register.
	localparam logic [1:0] FMT_RGB565 = 2'd0;
	localparam logic [1:0] FMT_RGB555 = 2'd1;
	localparam logic [1:0] FMT_RGB444 = 2'd2;

	// Pixel commands.
	localparam logic [1:0] CMD_OPAQUE    = 2'd0;
	localparam logic [1:0] CMD_ALPHA_COV = 2'd1;
	localparam logic [1:0] CMD_VAR_FILL  = 2'd2;
	localparam logic [1:0] CMD_COV_ONLY  = 2'd3;

	// What the back end does with a classified pixel.
	localparam logic [1:0] JOB_SKIP   = 2'd0;
	localparam logic [1:0] JOB_DIRECT = 2'd1;
	localparam logic [1:0] JOB_BLEND  = 2'd2;

	localparam logic [7:0] CH_FULL = 8'hFF;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] src_color;
		logic [7:0]  coverage;
		logic [7:0]  dst_first_byte;
		logic [7:0]  dst_second_byte;
	} pxb_in_t;

	typedef struct packed {
		logic [7:0] new_first_byte;
		logic [7:0] new_second_byte;
		logic       write_enable;
	} pxb_out_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  alpha;
		logic [23:0] src_rgb;
		logic [7:0]  dst0;
		logic [7:0]  dst1;
	} pxb_job_t;

endpackage

// File: src/packed_rgb_pixel_blender.sv
// Packed 16-bit pixel blender. Each input transfer carries one pixel: the two stored bytes
// of a destination pixel in RGB565, RGB555 or RGB444 (picked by the format register), an
// ARGB source color, a span coverage and a command, and it yields exactly one output
// transfer with the new pair of bytes and a write enable. The block takes one pixel per
// clock when the output side keeps taking results. A pixel passes through the front stage
// register, which classifies the pixel and forms the blend alpha with one 9x8 multiply
// and is loaded at the accepting edge, then through the queue and two back-end stages
// (per-channel multiply, then shift, add and repack into the output register).
// The queue between front and back holds QUEUE_DEPTH pixels so that either side can stall
// without holding up the other. Skipped pixels (variable fill with zero color alpha) come
// out with write_enable low and the destination bytes echoed. The format register may
// only be written while no pixel is in flight; format code 3 behaves as RGB565.
module packed_rgb_pixel_blender
	import pxb_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  pxb_in_t    in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output pxb_out_t   out_data,
	input  logic       cfg_we,
	input  logic [1:0] cfg_data
);

	// Front stage, queue and two back-end stages.
	localparam int CAPACITY = QUEUE_DEPTH + 3;
	localparam int FW       = $clog2(CAPACITY + 1);

	logic [1:0] pixel_format_q;

	logic       front_valid;
	logic       front_ready;
	pxb_job_t   front_job;
	logic       back_valid;
	logic       back_ready;
	pxb_job_t   back_job;

	logic [FW-1:0] in_flight_q;

	// Destination layout register; user writes only while block is idle; not checked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q <= FMT_RGB565;
		end else if (cfg_we) begin
			pixel_format_q <= cfg_data;
		end
	end

	pxb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.job_valid (front_valid),
		.job_ready (front_ready),
		.job       (front_job)
	);

	pxb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_job   (front_job),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_job    (back_job)
	);

	pxb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_format (pixel_format_q),
		.job_valid    (back_valid),
		.job_ready    (back_ready),
		.job          (back_job),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data)
	);

	// Number of pixels accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_flight_q <= '0;
		end else if ((in_valid && in_ready) && !(out_valid && out_ready)) begin
			in_flight_q <= in_flight_q + FW'(1);
		end else if (!(in_valid && in_ready) && (out_valid && out_ready)) begin
			in_flight_q <= in_flight_q - FW'(1);
		end
	end

	// The pipeline never holds more pixels than it has places for.
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight_q <= FW'(CAPACITY))
		else $error("more pixels in flight than the pipeline can hold");

	// A result is never presented without a pixel behind it.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight_q == '0 |-> !out_valid)
		else $error("output valid with no pixel in flight");

	// An empty block always takes a new pixel.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight_q == '0 |-> in_ready)
		else $error("empty block refuses input");

endmodule

// File: src/pxb_front.sv
module pxb_front
	import pxb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  pxb_in_t  in_data,
	output logic     job_valid,
	input  logic     job_ready,
	output pxb_job_t job
);

	logic       valid_s1;
	pxb_job_t   job_s1;
	logic [7:0] color_alpha;
	logic [8:0] alpha_inc;
	logic [16:0] alpha_prod;
	logic [7:0] alpha_cov;
	pxb_job_t   job_next;

	assign color_alpha = in_data.src_color[31:24];
	assign alpha_inc   = {1'b0, color_alpha} + 9'd1;
	assign alpha_prod  = alpha_inc * {1'b0, in_data.coverage};
	assign alpha_cov   = alpha_prod[15:8];

	always_comb begin
		job_next.alpha   = alpha_cov;
		job_next.src_rgb = in_data.src_color[23:0];
		job_next.dst0    = in_data.dst_first_byte;
		job_next.dst1    = in_data.dst_second_byte;
		job_next.kind    = JOB_BLEND;
		case (in_data.cmd)
			CMD_OPAQUE: begin
				job_next.kind = JOB_DIRECT;
			end
			CMD_ALPHA_COV: begin
				job_next.kind = JOB_BLEND;
			end
			CMD_VAR_FILL: begin
				if (color_alpha == 8'd0) begin
					job_next.kind = JOB_SKIP;
				end else if (color_alpha == CH_FULL && in_data.coverage == CH_FULL) begin
					job_next.kind = JOB_DIRECT;
				end
			end
			CMD_COV_ONLY: begin
				// Full color alpha times coverage reduces to the coverage itself.
				job_next.alpha = in_data.coverage;
				if (in_data.coverage == CH_FULL) begin
					job_next.kind = JOB_DIRECT;
				end
			end
			default: begin
				job_next.kind = JOB_BLEND;
			end
		endcase
	end

	assign in_ready  = !valid_s1 || job_ready;
	assign job_valid = valid_s1;
	assign job       = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			job_s1 <= job_next;
		end
	end

endmodule

// File: src/pxb_queue.sv
module pxb_queue
	import pxb_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  pxb_job_t push_job,
	output logic     pop_valid,
	input  logic     pop_ready,
	output pxb_job_t pop_job
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pxb_job_t        entries_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_job    = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// File: src/pxb_back.sv
module pxb_back
	import pxb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] pixel_format,
	input  logic       job_valid,
	output logic       job_ready,
	input  pxb_job_t   job,
	output logic       out_valid,
	input  logic       out_ready,
	output pxb_out_t   out_data
);

	typedef logic signed [18:0] prod_t;

	// Expands a stored pixel to 8-bit channels with zero low bits.
	function automatic logic [23:0] unpack_px(input logic [1:0] fmt, input logic [7:0] b0,
		input logic [7:0] b1);
		logic [23:0] rgb;
		case (fmt)
			FMT_RGB555: rgb = {b0[6:2], 3'b0, b0[1:0], b1[7:5], 3'b0, b1[4:0], 3'b0};
			FMT_RGB444: rgb = {b0[3:0], 4'b0, b1[7:4], 4'b0, b1[3:0], 4'b0};
			default:    rgb = {b0[7:3], 3'b0, b0[2:0], b1[7:5], 2'b0, b1[4:0], 3'b0};
		endcase
		return rgb;
	endfunction

	// Packs 8-bit channels into the two stored bytes.
	function automatic logic [15:0] pack_px(input logic [1:0] fmt, input logic [23:0] rgb);
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [15:0] px;
		r = rgb[23:16];
		g = rgb[15:8];
		b = rgb[7:0];
		case (fmt)
			FMT_RGB555: px = {1'b0, r[7:3], g[7:6], g[5:3], b[7:3]};
			FMT_RGB444: px = {4'b0, r[7:4], g[7:4], b[7:4]};
			default:    px = {r[7:3], g[7:5], g[4:2], b[7:3]};
		endcase
		return px;
	endfunction

	logic        valid_s1;
	logic        ready_s1;
	logic [1:0]  kind_s1;
	logic [23:0] src_s1;
	logic [23:0] dst_s1;
	logic [7:0]  dst0_s1;
	logic [7:0]  dst1_s1;
	prod_t       prod_s1 [3];

	logic        ready_s2;
	pxb_out_t    out_s2;
	logic        valid_s2;

	logic [23:0] dst_rgb;
	logic signed [9:0] alpha_inc;
	prod_t       prod_next [3];
	logic [23:0] blend_rgb;
	logic [23:0] chan_rgb;
	logic [15:0] packed_px;
	pxb_out_t    out_next;

	assign dst_rgb   = unpack_px(pixel_format, job.dst0, job.dst1);
	assign alpha_inc = $signed({2'b0, job.alpha}) + 10'sd1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod_next[i] = alpha_inc * ($signed({1'b0, job.src_rgb[8*i +: 8]})
				- $signed({1'b0, dst_rgb[8*i +: 8]}));
		end
	end

	assign ready_s2  = !valid_s2 || out_ready;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign job_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= job_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && ready_s1) begin
			kind_s1 <= job.kind;
			src_s1  <= job.src_rgb;
			dst_s1  <= dst_rgb;
			dst0_s1 <= job.dst0;
			dst1_s1 <= job.dst1;
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= prod_next[i];
			end
		end
	end

	// Floor shift of the product, then add back the destination channel.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			blend_rgb[8*i +: 8] = prod_s1[i][15:8] + dst_s1[8*i +: 8];
		end
	end

	assign chan_rgb  = (kind_s1 == JOB_DIRECT) ? src_s1 : blend_rgb;
	assign packed_px = pack_px(pixel_format, chan_rgb);

	always_comb begin
		if (kind_s1 == JOB_SKIP) begin
			out_next.new_first_byte  = dst0_s1;
			out_next.new_second_byte = dst1_s1;
			out_next.write_enable    = 1'b0;
		end else begin
			out_next.new_first_byte  = packed_px[15:8];
			out_next.new_second_byte = packed_px[7:0];
			out_next.write_enable    = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			out_s2 <= out_next;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = out_s2;

endmodule
